### rtl/lmrs_pkg.sv
// Shared types and constants of the LED matrix row scan controller.
package lmrs_pkg;

   localparam int BYTE_W      = 8;
   localparam int OP_W        = 2;
   localparam int X_W         = 6;
   localparam int Y_W         = 4;
   localparam int ROW_BYTES_W = 4;
   localparam int ROWS_W      = 5;
   localparam int ROW_SEL_W   = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [ROW_BYTES_W-1:0] RESET_ROW_BYTES = 4'd8;
   localparam logic [ROWS_W-1:0]      RESET_ROWS      = 5'd16;
   localparam logic [BYTE_W-1:0]      RESET_DATA_MASK = 8'hff;

   typedef enum logic [OP_W-1:0] {
      OP_SCAN      = 2'd0,
      OP_SET       = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_CLEAR_ALL = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_BYTES = 2'd0,
      CSR_ROWS      = 2'd1,
      CSR_DATA_MASK = 2'd2,
      CSR_ENABLE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    shift_byte;
      logic [ROW_SEL_W-1:0] row_select;
      logic                 last;
   } rsp_entry_type;

endpackage

### rtl/lmrs_if.sv
// Request and response channel interfaces of the LED matrix row scan controller.
interface lmrs_req_if import lmrs_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] op;
   logic [X_W-1:0]  x;
   logic [Y_W-1:0]  y;

   modport source (output valid, output op, output x, output y, input ready);
   modport sink (input valid, input op, input x, input y, output ready);
endinterface

interface lmrs_rsp_if import lmrs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    shift_byte;
   logic [ROW_SEL_W-1:0] row_select;
   logic                 last;

   modport source (output valid, output shift_byte, output row_select, output last,
                   input ready);
   modport sink (input valid, input shift_byte, input row_select, input last,
                 output ready);
endinterface

### rtl/led_matrix_row_scan_controller.sv
// Scan tick: the bit-serial row address multiplier handles one bit of row_bytes per
// cycle, then one byte a cycle is read while the output buffer has room for it.
// The first byte of a row passes the RAM read register and then the output buffer; a full
// output buffer holds the reads back. Set and clear pixel multiply, then do a
// read-modify-write through the RAM read and write ports; clear-all clears all valid bits.
// Reset is synchronous; per-byte valid bits clear the frame store at once, with no sweep.
module led_matrix_row_scan_controller import lmrs_pkg::*; #(
   parameter int MAX_ROW_BYTES = 8,
   parameter int MAX_ROWS      = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   lmrs_req_if.sink               req,
   lmrs_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH  = MAX_ROW_BYTES * MAX_ROWS;
   localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int PROD_W = 8;
   localparam int SUM_W  = 9;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_PIX_RD,
      S_PIX_WR,
      S_SCAN
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [X_W-1:0]       x_ff, x_in;
   logic [ROW_SEL_W-1:0] row_ff, row_in;
   logic [ROW_SEL_W-1:0] scan_row_ff, scan_row_in;
   logic [PROD_W-1:0]    mcand_ff, mcand_in;
   logic [ROW_BYTES_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [ROW_BYTES_W-1:0] k_ff, k_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [DEPTH-1:0]     vld_ff, vld_in;
   logic                 vld_rd_ff, vld_rd_in;
   logic                 inflight_ff, inflight_in;
   logic                 tag_last_ff, tag_last_in;
   logic [ROW_SEL_W-1:0] tag_rs_ff, tag_rs_in;
   rsp_entry_type        buf_ff [2];
   rsp_entry_type        buf_in [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   logic [ROW_BYTES_W-1:0] row_bytes_ff, row_bytes_in;
   logic [ROWS_W-1:0]      rows_ff, rows_in;
   logic [BYTE_W-1:0]      data_mask_ff, data_mask_in;
   logic                   enable_ff, enable_in;

   logic [ROW_BYTES_W-1:0] rb_eff;
   logic [ROWS_W-1:0]      nr_eff;
   logic [ROW_SEL_W-1:0]   cur_row;
   logic [ROWS_W-1:0]      row_inc;
   logic                   pop;
   logic [BYTE_W-1:0]      rd_byte;
   logic [BYTE_W-1:0]      bit_mask;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   lmrs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Geometry registers are clamped to what the store can hold.
   always_comb begin
      if (row_bytes_ff == '0) begin
         rb_eff = ROW_BYTES_W'(1);
      end else if (int'(row_bytes_ff) > MAX_ROW_BYTES) begin
         rb_eff = ROW_BYTES_W'(MAX_ROW_BYTES);
      end else begin
         rb_eff = row_bytes_ff;
      end
      if (rows_ff == '0) begin
         nr_eff = ROWS_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         nr_eff = ROWS_W'(MAX_ROWS);
      end else begin
         nr_eff = rows_ff;
      end
   end

   assign cur_row  = ({1'b0, scan_row_ff} >= nr_eff) ? '0 : scan_row_ff;
   assign row_inc  = {1'b0, row_ff} + ROWS_W'(1);
   assign pop      = rsp.valid && rsp.ready;
   assign rd_byte  = vld_rd_ff ? ram_rd_data : '0;
   assign bit_mask = BYTE_W'(1) << x_ff[2:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      row_in       = row_ff;
      scan_row_in  = scan_row_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      addr_in      = addr_ff;
      vld_in       = vld_ff;
      vld_rd_in    = vld_rd_ff;
      inflight_in  = 1'b0;
      tag_last_in  = tag_last_ff;
      tag_rs_in    = tag_rs_ff;
      buf_in       = buf_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      row_bytes_in = row_bytes_ff;
      rows_in      = rows_ff;
      data_mask_in = data_mask_ff;
      enable_in    = enable_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_BYTES: row_bytes_in = csr_wdata[ROW_BYTES_W-1:0];
            CSR_ROWS:      rows_in      = csr_wdata[ROWS_W-1:0];
            CSR_DATA_MASK: data_mask_in = csr_wdata[BYTE_W-1:0];
            CSR_ENABLE:    enable_in    = csr_wdata[0];
            default:       ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in     = op_type'(req.op);
               x_in      = req.x;
               acc_in    = '0;
               mplier_in = rb_eff;
               case (op_type'(req.op))
                  OP_CLEAR_ALL: vld_in = '0;
                  OP_SET, OP_CLEAR: begin
                     if (({1'b0, req.x[X_W-1:3]} < rb_eff) && ({1'b0, req.y} < nr_eff)) begin
                        mcand_in = PROD_W'(req.y);
                        state_in = S_MUL;
                     end
                  end
                  OP_SCAN: begin
                     if (enable_ff) begin
                        mcand_in = PROD_W'(cur_row);
                        row_in   = cur_row;
                        state_in = S_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            // Shift-add, one bit of the row byte count per cycle.
            if (mplier_ff == '0) begin
               if (op_ff == OP_SCAN) begin
                  k_in     = rb_eff;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_PIX_RD;
               end
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         S_PIX_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(SUM_W'(acc_ff) + SUM_W'(x_ff[X_W-1:3]));
            addr_in     = ram_rd_addr;
            vld_rd_in   = vld_ff[ram_rd_addr];
            state_in    = S_PIX_WR;
         end
         S_PIX_WR: begin
            ram_wr_en       = 1'b1;
            ram_wr_addr     = addr_ff;
            ram_wr_data     = (op_ff == OP_SET) ? (rd_byte | bit_mask) : (rd_byte & ~bit_mask);
            vld_in[addr_ff] = 1'b1;
            state_in        = S_IDLE;
         end
         S_SCAN: begin
            // Issue a read only when the output buffer has room for its byte.
            if (({1'b0, count_ff} + {2'b0, inflight_ff}) < (3'd2 + {2'b0, pop})) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(SUM_W'(acc_ff) + SUM_W'(k_ff) - SUM_W'(1));
               vld_rd_in   = vld_ff[ram_rd_addr];
               inflight_in = 1'b1;
               tag_last_in = (k_ff == ROW_BYTES_W'(1));
               tag_rs_in   = ROW_SEL_W'(nr_eff - ROWS_W'(1) - {1'b0, row_ff});
               k_in        = k_ff - ROW_BYTES_W'(1);
               if (k_ff == ROW_BYTES_W'(1)) begin
                  scan_row_in = (row_inc == nr_eff) ? '0 : row_inc[ROW_SEL_W-1:0];
                  state_in    = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (inflight_ff) begin
         buf_in[wr_ptr_ff].shift_byte = rd_byte ^ data_mask_ff;
         buf_in[wr_ptr_ff].row_select = tag_last_ff ? tag_rs_ff : '0;
         buf_in[wr_ptr_ff].last       = tag_last_ff;
         wr_ptr_in                    = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      count_in = count_ff + {1'b0, inflight_ff} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_row_ff  <= '0;
         vld_ff       <= '0;
         inflight_ff  <= 1'b0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= '0;
         row_bytes_ff <= RESET_ROW_BYTES;
         rows_ff      <= RESET_ROWS;
         data_mask_ff <= RESET_DATA_MASK;
         enable_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_row_ff  <= scan_row_in;
         vld_ff       <= vld_in;
         inflight_ff  <= inflight_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         row_bytes_ff <= row_bytes_in;
         rows_ff      <= rows_in;
         data_mask_ff <= data_mask_in;
         enable_ff    <= enable_in;
      end
      op_ff       <= op_in;
      x_ff        <= x_in;
      row_ff      <= row_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      k_ff        <= k_in;
      addr_ff     <= addr_in;
      vld_rd_ff   <= vld_rd_in;
      tag_last_ff <= tag_last_in;
      tag_rs_ff   <= tag_rs_in;
      buf_ff      <= buf_in;
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = (count_ff != '0);
   assign rsp.shift_byte = buf_ff[rd_ptr_ff].shift_byte;
   assign rsp.row_select = buf_ff[rd_ptr_ff].row_select;
   assign rsp.last       = buf_ff[rd_ptr_ff].last;

`ifndef SYNTHESIS
   // The output buffer never holds more than two items.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output buffer count out of range");

   // A returning read never lands in a full buffer unless an item leaves.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff && count_ff == 2'd2) |-> pop)
      else $error("read data arrived at a full output buffer");

   // A clear-all item has emptied the whole store in the next cycle.
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.op == OP_CLEAR_ALL) |=> (vld_ff == '0))
      else $error("clear-all left valid bytes in the store");
`endif

endmodule

### rtl/lmrs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lmrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/led_matrix_row_scan_controller_tb.sv
// Self-checking testbench of the LED matrix row scan controller with a built-in scan predictor.
module led_matrix_row_scan_controller_tb import lmrs_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_BYTES    = 128;
   localparam int MAX_RB         = 8;
   localparam int MAX_NR         = 16;
   localparam int IDLE_PERCENT   = 13;
   localparam int SETTLE_CYCLES  = 32;
   localparam int HOLD_CYCLES    = 400;

   typedef struct {
      op_type              op;
      logic [X_W-1:0]      x;
      logic [Y_W-1:0]      y;
   } pixel_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lmrs_req_if req_ch ();
   lmrs_rsp_if rsp_ch ();

   led_matrix_row_scan_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_cmd_type cmd_queue[$];
   pixel_cmd_type in_flight;
   rsp_entry_type row_bytes_due[$];

   // Predicted panel state and register copies.
   logic [BYTE_W-1:0]      frame_model [STORE_BYTES];
   int unsigned            scan_row_model;
   logic [ROW_BYTES_W-1:0] row_bytes_reg;
   logic [ROWS_W-1:0]      rows_reg;
   logic [BYTE_W-1:0]      mask_reg;
   logic                   enable_reg;

   int  error_count;
   int  cmds_accepted;
   int  bytes_checked;
   int  setting_count;
   bit  no_idle;
   bit  hold_go;
   logic rsp_hold;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_row_bytes();
      if (row_bytes_reg == 0) return 1;
      if (row_bytes_reg > MAX_RB) return MAX_RB;
      return row_bytes_reg;
   endfunction

   function automatic int unsigned eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_NR) return MAX_NR;
      return rows_reg;
   endfunction

   // Updates the panel state for one accepted item and queues the row bytes it produces.
   function automatic void scan_predict(pixel_cmd_type c);
      int unsigned rb;
      int unsigned nr;
      int unsigned row;
      int unsigned idx;
      rsp_entry_type e;
      rb = eff_row_bytes();
      nr = eff_rows();
      case (c.op)
         OP_SET, OP_CLEAR: begin
            if (c.x < rb * 8 && c.y < nr) begin
               idx = c.y * rb + c.x[5:3];
               frame_model[idx][c.x[2:0]] = (c.op == OP_SET);
            end
         end
         OP_CLEAR_ALL: begin
            foreach (frame_model[i]) frame_model[i] = '0;
         end
         OP_SCAN: begin
            if (enable_reg) begin
               // A scan row left beyond a shrunken row count restarts at row zero.
               row = (scan_row_model >= nr) ? 0 : scan_row_model;
               for (int k = rb; k > 0; k--) begin
                  idx = row * rb + k - 1;
                  e.shift_byte = frame_model[idx] ^ mask_reg;
                  e.row_select = (k == 1) ? ROW_SEL_W'(nr - 1 - row) : '0;
                  e.last       = (k == 1);
                  row_bytes_due.push_back(e);
               end
               scan_row_model = (row + 1) % nr;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic pixel_cmd_type random_cmd(int unsigned scan_pct);
      pixel_cmd_type c;
      int unsigned pick;
      int unsigned rb;
      int unsigned nr;
      rb = eff_row_bytes();
      nr = eff_rows();
      pick = $urandom_range(0, 99);
      c.x = X_W'($urandom_range(0, 63));
      c.y = Y_W'($urandom_range(0, 15));
      if (pick < scan_pct) begin
         c.op = OP_SCAN;
      end else if (pick < 97) begin
         c.op = ($urandom_range(0, 2) != 0) ? OP_SET : OP_CLEAR;
         // Most pixel writes land on the panel; the rest may fall outside it.
         if ($urandom_range(0, 4) != 0) begin
            c.x = X_W'($urandom_range(0, rb * 8 - 1));
            c.y = Y_W'($urandom_range(0, nr - 1));
         end
      end else begin
         c.op = OP_CLEAR_ALL;
      end
      return c;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ROW_BYTES: row_bytes_reg = value[ROW_BYTES_W-1:0];
         CSR_ROWS:      rows_reg      = value[ROWS_W-1:0];
         CSR_DATA_MASK: mask_reg      = value;
         CSR_ENABLE:    enable_reg    = value[0];
         default:       ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Upper bits of the narrower registers carry random junk that must be ignored.
   task automatic configure(int unsigned rb, int unsigned nr, int unsigned mask, bit en);
      write_csr(CSR_ROW_BYTES, {4'($urandom), 4'(rb)});
      write_csr(CSR_ROWS, {3'($urandom), 5'(nr)});
      write_csr(CSR_DATA_MASK, 8'(mask));
      write_csr(CSR_ENABLE, {7'($urandom), en});
      setting_count++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || req_ch.valid || row_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_cmd(op_type op, int unsigned x, int unsigned y);
      pixel_cmd_type c;
      c.op = op;
      c.x  = X_W'(x);
      c.y  = Y_W'(y);
      cmd_queue.push_back(c);
   endtask

   task automatic run_phase(int unsigned rb, int unsigned nr, int unsigned mask, bit en,
                            int unsigned n, int unsigned scan_pct);
      configure(rb, nr, mask, en);
      @(negedge clock);
      repeat (n) cmd_queue.push_back(random_cmd(scan_pct));
      wait_idle();
   endtask

   // Request driver: holds an offered item until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            scan_predict(in_flight);
            cmds_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (cmd_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               in_flight = cmd_queue.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.op    <= in_flight.op;
               req_ch.x     <= in_flight.x;
               req_ch.y     <= in_flight.y;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready generator.
   always @(posedge clock) begin
      rsp_entry_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (row_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h sel %0d last %0b",
                  rsp_ch.shift_byte, rsp_ch.row_select, rsp_ch.last));
            end else begin
               want = row_bytes_due.pop_front();
               bytes_checked++;
               if (rsp_ch.shift_byte !== want.shift_byte || rsp_ch.row_select !== want.row_select
                   || rsp_ch.last !== want.last)
                  report_mismatch($sformatf(
                     "byte %02h sel %0d last %0b, want %02h sel %0d last %0b",
                     rsp_ch.shift_byte, rsp_ch.row_select, rsp_ch.last,
                     want.shift_byte, want.row_select, want.last));
            end
         end
         rsp_ch.ready <= !rsp_hold && (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Long receiver hold-off so that the block backs up and stalls its input.
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      csr_we        = 1'b0;
      csr_index     = CSR_ROW_BYTES;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.op     = OP_SCAN;
      req_ch.x      = '0;
      req_ch.y      = '0;
      rsp_ch.ready  = 1'b0;
      rsp_hold      = 1'b0;
      no_idle       = 1'b0;
      hold_go       = 1'b0;
      error_count   = 0;
      cmds_accepted = 0;
      bytes_checked = 0;
      setting_count = 1;
      foreach (frame_model[i]) frame_model[i] = '0;
      scan_row_model = 0;
      row_bytes_reg  = RESET_ROW_BYTES;
      rows_reg       = RESET_ROWS;
      mask_reg       = RESET_DATA_MASK;
      enable_reg     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the panel is blanked, so the first tick must stay silent.
      @(negedge clock);
      queue_cmd(OP_SCAN, 5, 3);
      queue_cmd(OP_SET, 0, 0);
      queue_cmd(OP_SET, 63, 15);
      queue_cmd(OP_SET, 8, 1);
      queue_cmd(OP_SET, 7, 0);
      queue_cmd(OP_SET, 63, 0);
      wait_idle();

      write_csr(CSR_ENABLE, {7'($urandom), 1'b1});
      @(negedge clock);
      queue_cmd(OP_SCAN, 0, 0);
      queue_cmd(OP_SCAN, 63, 15);
      queue_cmd(OP_CLEAR, 0, 0);
      queue_cmd(OP_CLEAR, 8, 1);
      queue_cmd(OP_SCAN, 42, 9);
      queue_cmd(OP_CLEAR_ALL, 21, 6);
      queue_cmd(OP_SET, 5, 3);
      queue_cmd(OP_SCAN, 0, 0);
      wait_idle();

      // Zero geometry clamps to one byte and one row; the held scan row is then beyond it.
      configure(0, 0, 8'h00, 1'b1);
      @(negedge clock);
      queue_cmd(OP_SET, 7, 0);
      queue_cmd(OP_SET, 8, 0);
      queue_cmd(OP_SET, 0, 1);
      queue_cmd(OP_SCAN, 0, 0);
      queue_cmd(OP_SCAN, 0, 0);
      wait_idle();

      // Oversized geometry clamps to the full panel.
      configure(15, 31, 8'h5a, 1'b1);
      @(negedge clock);
      queue_cmd(OP_SET, 63, 15);
      queue_cmd(OP_SCAN, 0, 0);
      queue_cmd(OP_SCAN, 63, 15);
      wait_idle();

      run_phase(8, 16, 8'hff, 1'b1, 60, 30);
      run_phase(1, 1, 8'h00, 1'b1, 40, 30);
      repeat (2) run_phase($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 255),
                           1'b1, 50, 35);

      @(negedge clock);
      no_idle = 1'b1;
      run_phase(15, 31, $urandom_range(0, 255), 1'b1, 40, 35);
      @(negedge clock);
      no_idle = 1'b0;

      run_phase(8, 16, $urandom_range(0, 255), 1'b0, 20, 30);

      hold_go = 1'b1;
      run_phase(8, 16, 8'ha5, 1'b1, 40, 80);

      run_phase(2, 16, $urandom_range(0, 255), 1'b1, 50, 30);
      run_phase(8, 3, $urandom_range(0, 255), 1'b1, 50, 35);

      $display("covered %0d items over %0d register settings, %0d row bytes checked",
               cmds_accepted, setting_count, bytes_checked);
      $display("including clamped geometry, blanked scans, off-panel pixels and a long stall");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
